// ----- src/dec96r_pkg.sv -----
// Package for the 96-bit decimal integer rounding block.
// Holds field widths, operation codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dec96r_pkg;

  localparam int WORD_W  = 32;
  localparam int SCALE_W = 5;
  localparam int FUNC_W  = 2;
  localparam int CNT_W   = SCALE_W + 1;
  localparam int DIGIT_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_TRUNC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FLOOR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROUND  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NEGATE = 2'd3;

  typedef struct packed {
    logic load;
    logic en_hi;
    logic en_mid;
    logic en_lo;
    logic inc;
  } cmd_t;

  typedef struct packed {
    logic               neg_op;
    logic [SCALE_W-1:0] scale;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/dec96r_if.sv -----
// Valid/ready channel interfaces for the input and result items.
// Depends on dec96r_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dec96r_in_if;
  logic                               valid;
  logic                               ready;
  logic [dec96r_pkg::FUNC_W-1:0]      func;
  logic [dec96r_pkg::WORD_W-1:0]      mag_word_low;
  logic [dec96r_pkg::WORD_W-1:0]      mag_word_mid;
  logic [dec96r_pkg::WORD_W-1:0]      mag_word_high;
  logic [dec96r_pkg::SCALE_W-1:0]     dec_scale;
  logic                               neg_sign;

  modport source (output valid, func, mag_word_low, mag_word_mid, mag_word_high,
                  dec_scale, neg_sign, input ready);
  modport sink (input valid, func, mag_word_low, mag_word_mid, mag_word_high,
                dec_scale, neg_sign, output ready);
endinterface

interface dec96r_out_if;
  logic                               valid;
  logic                               ready;
  logic [dec96r_pkg::WORD_W-1:0]      out_word_low;
  logic [dec96r_pkg::WORD_W-1:0]      out_word_mid;
  logic [dec96r_pkg::WORD_W-1:0]      out_word_high;
  logic [dec96r_pkg::SCALE_W-1:0]     out_scale;
  logic                               out_sign;

  modport source (output valid, out_word_low, out_word_mid, out_word_high,
                  out_scale, out_sign, input ready);
  modport sink (input valid, out_word_low, out_word_mid, out_word_high,
                out_scale, out_sign, output ready);
endinterface

`default_nettype wire

// ----- src/dec96r_dp.sv -----
// Datapath: operand registers, three word-wide divide-by-ten units run as a
// wavefront, fraction tracking and the final increment. Depends on dec96r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dec96r_dp (
  input  wire logic                               clk,
  input  wire dec96r_pkg::cmd_t                   cmd,
  output dec96r_pkg::sts_t                        sts,
  input  wire logic [dec96r_pkg::FUNC_W-1:0]      func,
  input  wire logic [dec96r_pkg::WORD_W-1:0]      mag_word_low,
  input  wire logic [dec96r_pkg::WORD_W-1:0]      mag_word_mid,
  input  wire logic [dec96r_pkg::WORD_W-1:0]      mag_word_high,
  input  wire logic [dec96r_pkg::SCALE_W-1:0]     dec_scale,
  input  wire logic                               neg_sign,
  output logic [dec96r_pkg::WORD_W-1:0]           res_low,
  output logic [dec96r_pkg::WORD_W-1:0]           res_mid,
  output logic [dec96r_pkg::WORD_W-1:0]           res_high,
  output logic [dec96r_pkg::SCALE_W-1:0]          res_scale,
  output logic                                    res_sign
);

  localparam int W   = dec96r_pkg::WORD_W;
  localparam int DW  = dec96r_pkg::DIGIT_W;
  localparam int NW  = W + DW;
  localparam int SH  = NW + 3;
  localparam logic [NW-1:0] RECIP10 = NW'((72'd1 << SH) / 72'd10 + 72'd1);

  // Quotient in the upper W bits, remainder in the lower DW bits.
  function automatic logic [NW-1:0] div10(input logic [NW-1:0] num);
    logic [2*NW-1:0] prod;
    logic [W-1:0]    q;
    logic [NW-1:0]   q10;
    logic [NW-1:0]   rem;
    prod = num * RECIP10;
    q    = prod[SH+W-1:SH];
    q10  = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
    rem  = num - q10;
    return {q, rem[DW-1:0]};
  endfunction

  logic [dec96r_pkg::FUNC_W-1:0]  op;
  logic [dec96r_pkg::SCALE_W-1:0] scale;
  logic                           sign;
  logic [W-1:0]                   w_hi;
  logic [W-1:0]                   w_mid;
  logic [W-1:0]                   w_lo;
  logic [DW-1:0]                  r_hm;
  logic [DW-1:0]                  r_ml;
  logic [DW-1:0]                  last_digit;
  logic                           frac_nz;
  logic [NW-1:0]                  d_hi;
  logic [NW-1:0]                  d_mid;
  logic [NW-1:0]                  d_lo;
  logic                           inc_needed;
  logic [3*W-1:0]                 mag_inc;

  assign d_hi  = div10({{DW{1'b0}}, w_hi});
  assign d_mid = div10({r_hm, w_mid});
  assign d_lo  = div10({r_ml, w_lo});

  assign inc_needed = ((op == dec96r_pkg::FUNC_FLOOR) && sign && frac_nz) ||
                      ((op == dec96r_pkg::FUNC_ROUND) && (scale != '0) &&
                       (last_digit >= DW'(5)));
  assign mag_inc    = {w_hi, w_mid, w_lo} + {{(3*W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= func;
      scale      <= dec_scale;
      sign       <= neg_sign;
      w_hi       <= mag_word_high;
      w_mid      <= mag_word_mid;
      w_lo       <= mag_word_low;
      r_hm       <= '0;
      r_ml       <= '0;
      last_digit <= '0;
      frac_nz    <= 1'b0;
    end else if (cmd.inc) begin
      if (inc_needed) begin
        {w_hi, w_mid, w_lo} <= mag_inc;
      end
    end else begin
      if (cmd.en_hi) begin
        w_hi <= d_hi[NW-1:DW];
        r_hm <= d_hi[DW-1:0];
      end
      if (cmd.en_mid) begin
        w_mid <= d_mid[NW-1:DW];
        r_ml  <= d_mid[DW-1:0];
      end
      if (cmd.en_lo) begin
        w_lo       <= d_lo[NW-1:DW];
        last_digit <= d_lo[DW-1:0];
        if (d_lo[DW-1:0] != '0) begin
          frac_nz <= 1'b1;
        end
      end
    end
  end

  assign sts.neg_op = (op == dec96r_pkg::FUNC_NEGATE);
  assign sts.scale  = scale;

  assign res_low   = w_lo;
  assign res_mid   = w_mid;
  assign res_high  = w_hi;
  assign res_scale = sts.neg_op ? scale : '0;
  assign res_sign  = sts.neg_op ? ~sign : sign;

endmodule

`default_nettype wire

// ----- src/dec96r_ctrl.sv -----
// Controller: handshakes, step counter and sequencing of the divide wavefront.
// Depends on dec96r_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dec96r_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dec96r_pkg::sts_t  sts,
  output dec96r_pkg::cmd_t       cmd
);

  localparam int CW = dec96r_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_INC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] scale_ext;
  logic [CW-1:0] scale_end;
  logic          in_acc;

  assign scale_ext = {1'b0, sts.scale};
  assign scale_end = scale_ext + CW'(1);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cmd.load   = in_acc;
    cmd.inc    = (state == S_INC);
    cmd.en_hi  = (state == S_DIV) && !sts.neg_op && (cnt < scale_ext);
    cmd.en_mid = (state == S_DIV) && !sts.neg_op && (cnt != '0) &&
                 (cnt <= scale_ext);
    cmd.en_lo  = (state == S_DIV) && !sts.neg_op && (cnt >= CW'(2)) &&
                 (cnt <= scale_end);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_acc) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cnt_next = cnt + CW'(1);
        if (sts.neg_op || (cnt == scale_end)) begin
          state_next = S_INC;
        end
      end
      S_INC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_acc_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_DIV) && (cnt == '0))
    else $error("accepted item did not start the divide sequence");

  a_inc_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.inc |-> !(cmd.en_hi || cmd.en_mid || cmd.en_lo || cmd.load))
    else $error("increment overlaps a divide step or load");

  a_negate_no_div: assert property (@(posedge clk) disable iff (rst)
    sts.neg_op |-> !(cmd.en_hi || cmd.en_mid || cmd.en_lo))
    else $error("divide step issued for negate");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= scale_end))
    else $error("step counter ran past the scale");

  a_inc_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.inc |=> out_valid && !in_ready)
    else $error("result not presented after increment step");
`endif

endmodule

`default_nettype wire

// ----- src/decimal96_integer_rounding.sv -----
// Accepts a new item only when idle, after the previous result has been taken;
// negate issues no divide steps.
// One step of the divide wavefront per cycle: three word divide-by-ten units
// run one word apart, followed by an increment step.
// Reset (rst, synchronous, active high) returns the controller to idle;
// the datapath registers hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module decimal96_integer_rounding (
  input  wire logic    clk,
  input  wire logic    rst,
  dec96r_in_if.sink    in_ch,
  dec96r_out_if.source out_ch
);

  dec96r_pkg::cmd_t cmd;
  dec96r_pkg::sts_t sts;

  dec96r_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dec96r_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .func          (in_ch.func),
    .mag_word_low  (in_ch.mag_word_low),
    .mag_word_mid  (in_ch.mag_word_mid),
    .mag_word_high (in_ch.mag_word_high),
    .dec_scale     (in_ch.dec_scale),
    .neg_sign      (in_ch.neg_sign),
    .res_low       (out_ch.out_word_low),
    .res_mid       (out_ch.out_word_mid),
    .res_high      (out_ch.out_word_high),
    .res_scale     (out_ch.out_scale),
    .res_sign      (out_ch.out_sign)
  );

endmodule

`default_nettype wire

// ----- test/tb_decimal96_integer_rounding.sv -----
// Testbench for decimal96_integer_rounding: directed table then bursty random items,
// each result checked in order against a table value or an in-bench rounding predictor.
// Depends on dec96r_pkg, dec96r_in_if, dec96r_out_if and the block under test.
`timescale 1ns / 1ps

module tb_decimal96_integer_rounding;

  localparam int WORD_W  = dec96r_pkg::WORD_W;
  localparam int FUNC_W  = dec96r_pkg::FUNC_W;
  localparam int SCALE_W = dec96r_pkg::SCALE_W;
  localparam int DIGIT_W = dec96r_pkg::DIGIT_W;
  localparam int MAG_W = 3 * WORD_W;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] TEN = MAG_W'(10);
  localparam logic [DIGIT_W-1:0] HALF_DIGIT = DIGIT_W'(5);
  localparam int RANDOM_ITEMS = 650;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [12:0] STALL_PATTERN = 13'b1_0110_1110_0101;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [MAG_W-1:0]   mag;
    logic [SCALE_W-1:0] scale;
    logic               sign;
  } dec_item_t;

  typedef struct {
    logic [MAG_W-1:0]   mag;
    logic [SCALE_W-1:0] scale;
    logic               sign;
  } dec_res_t;

  typedef struct {
    dec_item_t item;
    bit        typed;
    dec_res_t  result;
  } dir_row_t;

  logic clk;
  logic rst;

  dec96r_in_if  in_ch ();
  dec96r_out_if out_ch ();

  decimal96_integer_rounding u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dec_res_t pending_results[$];
  dir_row_t dir_rows[$];
  dec_res_t head_result;
  int       mismatch_count = 0;
  int       rx_cycle;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic dec_res_t rounded_result(dec_item_t it);
    dec_res_t           r;
    logic [MAG_W-1:0]   m;
    logic [DIGIT_W-1:0] digit;
    bit                 any_frac;
    m = it.mag;
    digit = '0;
    any_frac = 1'b0;
    r.scale = '0;
    r.sign = it.sign;
    if (it.func == dec96r_pkg::FUNC_NEGATE) begin
      r.scale = it.scale;
      r.sign = ~it.sign;
    end else begin
      for (int i = 0; i < it.scale; i++) begin
        digit = DIGIT_W'(m % TEN);
        m = m / TEN;
        if (digit != 0) any_frac = 1'b1;
      end
      if (it.func == dec96r_pkg::FUNC_FLOOR && it.sign && any_frac) m = m + 1'b1;
      if (it.func == dec96r_pkg::FUNC_ROUND && it.scale != 0 && digit >= HALF_DIGIT)
        m = m + 1'b1;
    end
    r.mag = m;
    return r;
  endfunction

  function automatic void add_row(logic [FUNC_W-1:0] func, logic [MAG_W-1:0] mag,
                                  logic [SCALE_W-1:0] scale, logic sign, bit typed,
                                  logic [MAG_W-1:0] exp_mag = '0,
                                  logic [SCALE_W-1:0] exp_scale = '0,
                                  logic exp_sign = 1'b0);
    dir_row_t row;
    row.item.func = func;
    row.item.mag = mag;
    row.item.scale = scale;
    row.item.sign = sign;
    row.typed = typed;
    row.result.mag = exp_mag;
    row.result.scale = exp_scale;
    row.result.sign = exp_sign;
    dir_rows.push_back(row);
  endfunction

  function automatic dec_item_t random_item();
    dec_item_t        it;
    logic [MAG_W-1:0] wide;
    logic [MAG_W-1:0] pow;
    logic [MAG_W-1:0] q;
    logic [MAG_W-1:0] frac;
    int               s;
    wide = {$urandom, $urandom, $urandom};
    it.func = FUNC_W'($urandom_range(dec96r_pkg::FUNC_TRUNC, dec96r_pkg::FUNC_NEGATE));
    it.sign = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        s = $urandom_range(29, 31);
        it.mag = wide;
      end
      1, 2: begin
        s = $urandom_range(0, 28);
        it.mag = wide;
      end
      3: begin
        s = $urandom_range(0, 31);
        it.mag = wide >> $urandom_range(0, MAG_W - 1);
      end
      default: begin
        s = $urandom_range(1, 28);
        pow = MAG_W'(1);
        for (int k = 0; k < s; k++) pow = pow * TEN;
        q = (wide >> $urandom_range(0, MAG_W - 1)) / pow;
        if (q != 0) q = q - 1'b1;
        case ($urandom_range(0, 4))
          0: frac = '0;
          1: frac = pow / 2;
          2: frac = pow / 2 - 1'b1;
          3: frac = {$urandom, $urandom, $urandom} % pow;
          default: frac = pow - 1'b1;
        endcase
        it.mag = q * pow + frac;
      end
    endcase
    it.scale = s[SCALE_W-1:0];
    return it;
  endfunction

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  task automatic send_item(input dec_item_t it, input dec_res_t exp_res);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= it.func;
    in_ch.mag_word_low  <= it.mag[WORD_W-1:0];
    in_ch.mag_word_mid  <= it.mag[2*WORD_W-1:WORD_W];
    in_ch.mag_word_high <= it.mag[MAG_W-1:2*WORD_W];
    in_ch.dec_scale     <= it.scale;
    in_ch.neg_sign      <= it.sign;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(exp_res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 400) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= STALL_PATTERN[rx_cycle % 13];
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected item: mag %h scale %0d sign %b",
                     {out_ch.out_word_high, out_ch.out_word_mid, out_ch.out_word_low},
                     out_ch.out_scale, out_ch.out_sign));
      end else begin
        head_result = pending_results.pop_front();
        if (out_ch.out_word_low !== head_result.mag[WORD_W-1:0] ||
            out_ch.out_word_mid !== head_result.mag[2*WORD_W-1:WORD_W] ||
            out_ch.out_word_high !== head_result.mag[MAG_W-1:2*WORD_W] ||
            out_ch.out_scale !== head_result.scale ||
            out_ch.out_sign !== head_result.sign) begin
          log_mismatch($sformatf(
            "mismatch: expected mag %h scale %0d sign %b, got mag %h scale %0d sign %b",
            head_result.mag, head_result.scale, head_result.sign,
            {out_ch.out_word_high, out_ch.out_word_mid, out_ch.out_word_low},
            out_ch.out_scale, out_ch.out_sign));
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    dec_item_t it;
    int        sent;
    int        burst;
    int        gap;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = dec96r_pkg::FUNC_TRUNC;
    in_ch.mag_word_low = '0;
    in_ch.mag_word_mid = '0;
    in_ch.mag_word_high = '0;
    in_ch.dec_scale = '0;
    in_ch.neg_sign = 1'b0;

    add_row(dec96r_pkg::FUNC_TRUNC,  MAG_MAX, 5'd0,  1'b0, 1'b1, MAG_MAX, 5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  MAG_MAX, 5'd0,  1'b1, 1'b1, MAG_MAX, 5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_ROUND,  MAG_MAX, 5'd0,  1'b0, 1'b1, MAG_MAX, 5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_TRUNC,  '0,      5'd5,  1'b1, 1'b1, '0,      5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_FLOOR,  '0,      5'd28, 1'b1, 1'b1, '0,      5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_NEGATE, '0,      5'd0,  1'b0, 1'b1, '0,      5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_NEGATE, MAG_MAX, 5'd28, 1'b1, 1'b1, MAG_MAX, 5'd28, 1'b0);
    add_row(dec96r_pkg::FUNC_NEGATE, 96'd12345, 5'd31, 1'b0, 1'b1, 96'd12345, 5'd31, 1'b1);
    add_row(dec96r_pkg::FUNC_TRUNC,  MAG_MAX, 5'd31, 1'b0, 1'b1, '0,      5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  MAG_MAX, 5'd31, 1'b1, 1'b1, 96'd1,   5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd15,  5'd1,  1'b0, 1'b1, 96'd2,   5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd14,  5'd1,  1'b1, 1'b1, 96'd1,   5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd25,  5'd1,  1'b0, 1'b1, 96'd3,   5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  96'd15,  5'd1,  1'b1, 1'b1, 96'd2,   5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_FLOOR,  96'd15,  5'd1,  1'b0, 1'b1, 96'd1,   5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  96'd10,  5'd1,  1'b1, 1'b1, 96'd1,   5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd150, 5'd2,  1'b1, 1'b1, 96'd2,   5'd0, 1'b1);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd149, 5'd2,  1'b0, 1'b1, 96'd1,   5'd0, 1'b0);
    add_row(dec96r_pkg::FUNC_TRUNC,  MAG_MAX, 5'd28, 1'b1, 1'b0);
    add_row(dec96r_pkg::FUNC_ROUND,  MAG_MAX, 5'd28, 1'b0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  MAG_MAX, 5'd28, 1'b1, 1'b0);
    add_row(dec96r_pkg::FUNC_ROUND,  MAG_MAX, 5'd29, 1'b1, 1'b0);
    add_row(dec96r_pkg::FUNC_ROUND,  96'd5,   5'd29, 1'b0, 1'b0);
    add_row(dec96r_pkg::FUNC_TRUNC,  {24{4'h5}}, 5'd13, 1'b0, 1'b0);
    add_row(dec96r_pkg::FUNC_FLOOR,  {24{4'hA}}, 5'd7,  1'b1, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item,
                dir_rows[i].typed ? dir_rows[i].result : rounded_result(dir_rows[i].item));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        it = random_item();
        send_item(it, rounded_result(it));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- decimal96_integer_rounding.f -----
src/dec96r_pkg.sv
src/dec96r_if.sv
src/dec96r_dp.sv
src/dec96r_ctrl.sv
src/decimal96_integer_rounding.sv
test/tb_decimal96_integer_rounding.sv
